// ===== hdl/pwm_pdc_pkg.sv =====
// Shared widths, constants and status codes of the PWM period and duty calculator.
`default_nettype none

package pwm_pdc_pkg;

    localparam int FREQ_W    = 10;
    localparam int DUTY_W    = 7;
    localparam int COUNT_W   = 17;
    localparam int STATUS_W  = 2;
    localparam int PRODUCT_W = DUTY_W + COUNT_W;

    localparam int CLOCK_NUM = 10488000;
    localparam int PRESCALE  = 128;

    // floor(a / (b * c)) equals floor(floor(a / b) / c), so the prescale is folded in here.
    localparam logic [COUNT_W-1:0] PERIOD_NUM = COUNT_W'(CLOCK_NUM / PRESCALE);
    localparam logic [DUTY_W-1:0]  PERCENT    = DUTY_W'(100);
    localparam logic [COUNT_W-1:0] TIMER_MAX  = COUNT_W'(65535);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_FREQ = 2'd1,
        ST_TOO_BIG   = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/pwm_period_duty_calculator.sv =====
// Throughput: one word per unstalled cycle; each of the two 17-cell division rows retires one
// quotient bit per cell, with a multiplier stage between them and an output register.
// A stalled output holds the whole pipeline in place; a word is taken whenever o_stall is low.
// Reset is synchronous and active low; it clears every valid bit, data registers keep theirs.
`default_nettype none

module pwm_period_duty_calculator
    import pwm_pdc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [FREQ_W-1:0]   i_frequency_hz,
    input  wire logic [DUTY_W-1:0]   i_duty_percent,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [COUNT_W-1:0]       o_period_count,
    output logic [COUNT_W-1:0]       o_compare_count,
    output logic [STATUS_W-1:0]      o_status
);

    localparam int SIDE_B_W = COUNT_W + 1;

    logic                 w_en;

    logic                 w_a_valid;
    logic [COUNT_W-1:0]   w_a_num;
    logic [FREQ_W-1:0]    w_a_dvs;
    logic [DUTY_W-1:0]    w_a_side;

    logic                 r_mul_valid;
    logic [PRODUCT_W-1:0] r_product;
    logic [COUNT_W-1:0]   r_mul_period;
    logic                 r_mul_zero;

    logic                 w_b_valid;
    logic [COUNT_W-1:0]   w_b_num;
    logic [SIDE_B_W-1:0]  w_b_side;

    logic                 r_out_valid;
    logic [COUNT_W-1:0]   r_period;
    logic [COUNT_W-1:0]   r_compare;
    t_status              r_status;
    logic [COUNT_W-1:0]   n_period;
    logic [COUNT_W-1:0]   n_compare;
    t_status              n_status;

    // Everything moves together unless a finished word is waiting on a stalled sink.
    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    pwm_pdc_div_chain #(
        .DVS_W  (FREQ_W),
        .NUM_W  (COUNT_W),
        .SIDE_W (DUTY_W)
    ) u_period_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_rem   ('0),
        .i_num   (PERIOD_NUM),
        .i_dvs   (i_frequency_hz),
        .i_side  (i_duty_percent),
        .o_valid (w_a_valid),
        .o_rem   (),
        .o_num   (w_a_num),
        .o_dvs   (w_a_dvs),
        .o_side  (w_a_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (w_en) begin
            r_mul_valid <= w_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_product    <= PRODUCT_W'(w_a_side) * PRODUCT_W'(w_a_num);
            r_mul_period <= w_a_num;
            r_mul_zero   <= (w_a_dvs == '0);
        end
    end

    // For a non-zero frequency the product never exceeds 127 * 81937, so its top bits start
    // below the divisor and seventeen steps give the whole quotient.
    pwm_pdc_div_chain #(
        .DVS_W  (DUTY_W),
        .NUM_W  (COUNT_W),
        .SIDE_W (SIDE_B_W)
    ) u_compare_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_mul_valid),
        .i_rem   (r_product[PRODUCT_W-1:COUNT_W]),
        .i_num   (r_product[COUNT_W-1:0]),
        .i_dvs   (PERCENT),
        .i_side  ({r_mul_zero, r_mul_period}),
        .o_valid (w_b_valid),
        .o_rem   (),
        .o_num   (w_b_num),
        .o_dvs   (),
        .o_side  (w_b_side)
    );

    always_comb begin
        if (w_b_side[COUNT_W]) begin
            n_period  = '0;
            n_compare = '0;
            n_status  = ST_ZERO_FREQ;
        end else begin
            n_period  = w_b_side[COUNT_W-1:0];
            n_compare = w_b_num;
            n_status  = (w_b_side[COUNT_W-1:0] > TIMER_MAX) ? ST_TOO_BIG : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_period  <= n_period;
            r_compare <= n_compare;
            r_status  <= n_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_period_count  = r_period;
    assign o_compare_count = r_compare;
    assign o_status        = r_status;

endmodule

`default_nettype wire

// ===== hdl/pwm_pdc_div_cell.sv =====
// One restoring division step: trial subtract, one quotient bit, registered hand-over.
`default_nettype none

module pwm_pdc_div_cell #(
    parameter int DVS_W  = 10,
    parameter int NUM_W  = 17,
    parameter int SIDE_W = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [DVS_W-1:0]  i_rem,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DVS_W-1:0]  i_dvs,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [DVS_W-1:0]       o_rem,
    output logic [NUM_W-1:0]       o_num,
    output logic [DVS_W-1:0]       o_dvs,
    output logic [SIDE_W-1:0]      o_side
);

    logic              r_valid;
    logic [DVS_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_num;
    logic [DVS_W-1:0]  r_dvs;
    logic [SIDE_W-1:0] r_side;

    logic [DVS_W:0]    w_trial;
    logic [DVS_W:0]    w_diff;
    logic              w_fit;
    logic [DVS_W-1:0]  n_rem;
    logic [NUM_W-1:0]  n_num;

    // The dividend leaves the top of the word as quotient bits enter at the bottom.
    always_comb begin
        w_trial = {i_rem, i_num[NUM_W-1]};
        w_diff  = w_trial - {1'b0, i_dvs};
        w_fit   = (w_trial >= {1'b0, i_dvs});
        n_rem   = w_fit ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
        n_num   = {i_num[NUM_W-2:0], w_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_num  <= n_num;
            r_dvs  <= i_dvs;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_dvs   = r_dvs;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== hdl/pwm_pdc_div_chain.sv =====
// A row of division cells, one per quotient bit, each passing its word to the next.
`default_nettype none

module pwm_pdc_div_chain #(
    parameter int DVS_W  = 10,
    parameter int NUM_W  = 17,
    parameter int SIDE_W = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [DVS_W-1:0]  i_rem,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DVS_W-1:0]  i_dvs,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [DVS_W-1:0]       o_rem,
    output logic [NUM_W-1:0]       o_num,
    output logic [DVS_W-1:0]       o_dvs,
    output logic [SIDE_W-1:0]      o_side
);

    logic              w_valid [NUM_W+1];
    logic [DVS_W-1:0]  w_rem   [NUM_W+1];
    logic [NUM_W-1:0]  w_num   [NUM_W+1];
    logic [DVS_W-1:0]  w_dvs   [NUM_W+1];
    logic [SIDE_W-1:0] w_side  [NUM_W+1];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = i_rem;
    assign w_num[0]   = i_num;
    assign w_dvs[0]   = i_dvs;
    assign w_side[0]  = i_side;

    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        pwm_pdc_div_cell #(
            .DVS_W  (DVS_W),
            .NUM_W  (NUM_W),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[g]),
            .i_rem   (w_rem[g]),
            .i_num   (w_num[g]),
            .i_dvs   (w_dvs[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_num   (w_num[g+1]),
            .o_dvs   (w_dvs[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    assign o_valid = w_valid[NUM_W];
    assign o_rem   = w_rem[NUM_W];
    assign o_num   = w_num[NUM_W];
    assign o_dvs   = w_dvs[NUM_W];
    assign o_side  = w_side[NUM_W];

endmodule

`default_nettype wire

// ===== hdl/pwm_pdc_checker.sv =====
// Port-level checks of the PWM period and duty calculator, bound to its top level.
`default_nettype none

module pwm_pdc_checker
    import pwm_pdc_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire logic [FREQ_W-1:0]   i_frequency_hz,
    input wire logic [DUTY_W-1:0]   i_duty_percent,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic [COUNT_W-1:0]  o_period_count,
    input wire logic [COUNT_W-1:0]  o_compare_count,
    input wire logic [STATUS_W-1:0] o_status
);

    // A result word held back by the sink must stay put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_period_count)
            && $stable(o_compare_count) && $stable(o_status))
        else $error("result word changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_zero_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_ZERO_FREQ |-> o_period_count == '0
            && o_compare_count == '0)
        else $error("zero frequency gave non-zero counts");

    a_ok_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |-> o_period_count <= TIMER_MAX
            && o_period_count != '0)
        else $error("period out of range for an ok status");

    a_big_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_period_count > TIMER_MAX |-> o_status == ST_TOO_BIG)
        else $error("oversized period not flagged");

endmodule

bind pwm_period_duty_calculator pwm_pdc_checker u_pwm_pdc_checker (.*);

`default_nettype wire

// ===== verif/pwm_period_duty_calculator_test.sv =====
// Self-checking testbench for the PWM period and duty calculator.
`timescale 1ns / 100ps

module pwm_period_duty_calculator_test
    import pwm_pdc_pkg::*;
();

    localparam int DIRECTED_N       = 20;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES     = 40;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int REPORT_LIMIT     = 10;

    typedef struct {
        logic [FREQ_W-1:0]  freq;
        logic [DUTY_W-1:0]  duty;
        logic [COUNT_W-1:0] period;
        logic [COUNT_W-1:0] compare;
        t_status            status;
    } t_timer_counts;

    class t_timer_count_ledger;
        t_timer_counts expected_counts[$];
        int            words_checked;
        int            mismatches;

        function t_timer_counts predict_counts(logic [FREQ_W-1:0] freq,
                                               logic [DUTY_W-1:0] duty);
            t_timer_counts counts;
            int unsigned   divisor;
            int unsigned   period;
            int unsigned   compare;
            counts.freq = freq;
            counts.duty = duty;
            if (freq == '0) begin
                counts.period  = '0;
                counts.compare = '0;
                counts.status  = ST_ZERO_FREQ;
            end else begin
                divisor = PRESCALE * int'(freq);
                period  = CLOCK_NUM / divisor;
                compare = (int'(duty) * period) / int'(PERCENT);
                counts.period  = COUNT_W'(period);
                counts.compare = COUNT_W'(compare);
                counts.status  = (period > int'(TIMER_MAX)) ? ST_TOO_BIG : ST_OK;
            end
            return counts;
        endfunction

        function void note_request(logic [FREQ_W-1:0] freq, logic [DUTY_W-1:0] duty);
            expected_counts.push_back(predict_counts(freq, duty));
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("Mismatch: %s", msg);
            end
        endfunction

        function void check_result(logic [COUNT_W-1:0] period, logic [COUNT_W-1:0] compare,
                                   logic [STATUS_W-1:0] status);
            t_timer_counts want;
            words_checked++;
            if (expected_counts.size() == 0) begin
                report($sformatf({"result word with nothing outstanding: ",
                                  "period %0d compare %0d status %0d"},
                                 period, compare, status));
            end else begin
                want = expected_counts.pop_front();
                if (period !== want.period || compare !== want.compare ||
                        status !== want.status) begin
                    report($sformatf({"freq %0d duty %0d: period %0d/%0d compare %0d/%0d ",
                                      "status %0d/%0d (expected/actual)"},
                                     want.freq, want.duty, want.period, period,
                                     want.compare, compare, want.status, status));
                end
            end
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction

        function void close_out();
            if (expected_counts.size() != 0) begin
                report($sformatf("%0d expected result words never arrived",
                                 expected_counts.size()));
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [FREQ_W-1:0]  i_frequency_hz;
    logic [DUTY_W-1:0]  i_duty_percent;
    logic               o_valid;
    logic               i_stall;
    logic [COUNT_W-1:0] o_period_count;
    logic [COUNT_W-1:0] o_compare_count;
    logic [STATUS_W-1:0] o_status;

    t_timer_count_ledger ledger = new();

    bit sender_idles;
    bit receiver_idles;
    bit hold_request;
    int words_sent;
    int input_stall_cycles;
    int cycle_count;

    int directed_freq [DIRECTED_N] = '{0, 0, 1, 1, 2, 3, 999, 999, 1000, 1023,
                                       1023, 512, 341, 82, 81, 5, 0, 1023, 10, 100};
    int directed_duty [DIRECTED_N] = '{0, 127, 0, 99, 127, 50, 0, 99, 1, 127,
                                       0, 64, 85, 99, 100, 33, 55, 42, 127, 1};

    pwm_period_duty_calculator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_frequency_hz  (i_frequency_hz),
        .i_duty_percent  (i_duty_percent),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_period_count  (o_period_count),
        .o_compare_count (o_compare_count),
        .o_status        (o_status)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words outstanding",
                     cycle_count, ledger.pending());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Both handshakes are sampled here with the values that held before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                ledger.check_result(o_period_count, o_compare_count, o_status);
            end
            if (i_valid && o_stall) begin
                input_stall_cycles <= input_stall_cycles + 1;
            end
        end
    end

    task automatic send_request(input logic [FREQ_W-1:0] freq,
                                input logic [DUTY_W-1:0] duty, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_frequency_hz <= freq;
        i_duty_percent <= duty;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        ledger.note_request(freq, duty);
        words_sent++;
    endtask

    task automatic send_random(input int count);
        int                pick;
        int                gap;
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                freq = '0;
            end else if (pick < 10) begin
                freq = FREQ_W'($urandom_range(1, 8));
            end else if (pick < 22) begin
                freq = FREQ_W'($urandom);
            end else begin
                freq = FREQ_W'($urandom_range(1, 999));
            end
            if ($urandom_range(0, 99) < 85) begin
                duty = DUTY_W'($urandom_range(0, 99));
            end else begin
                duty = DUTY_W'($urandom);
            end
            gap = sender_idles ? $urandom_range(0, 9) : 0;
            send_request(freq, duty, gap);
        end
    endtask

    // The sender stops offering and waits for the block to hand back every word.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    initial begin : receiver
        int hold;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold = LONG_HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                hold = receiver_idles ? $urandom_range(0, 9) : 0;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_frequency_hz = '0;
        i_duty_percent = '0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        hold_request   = 1'b0;
        words_sent     = 0;
        input_stall_cycles = 0;
        cycle_count    = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero frequency, the over-range period, the largest duty and frequency codes.
        for (int k = 0; k < DIRECTED_N; k++) begin
            send_request(FREQ_W'(directed_freq[k]), DUTY_W'(directed_duty[k]),
                         $urandom_range(0, 9));
        end
        send_random(250);
        drain_results();

        // Output held back for a long stretch while words keep coming back to back.
        sender_idles = 1'b0;
        hold_request = 1'b1;
        send_random(100);
        drain_results();

        receiver_idles = 1'b0;
        send_random(200);
        drain_results();

        sender_idles = 1'b1;
        send_random(140);
        sender_idles   = 1'b0;
        receiver_idles = 1'b1;
        send_random(140);
        drain_results();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        ledger.close_out();
        $display("Sent %0d request words and checked %0d result words;",
                 words_sent, ledger.words_checked);
        $display("input held back %0d cycles; zero, over-range and oversized inputs were mixed in.",
                 input_stall_cycles);
        if (ledger.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
